@@ src/vfdw_pkg.sv @@
package vfdw_pkg;

    localparam int unsigned WORD_BITS   = 48;
    localparam int unsigned CW_BITS     = 3 * WORD_BITS;
    localparam int unsigned WHITE_START = 23;
    localparam int unsigned WHITE_LEN   = 114;
    localparam int unsigned LCG_BITS    = 16;
    localparam int unsigned SEED_SHIFT  = 4;
    localparam int unsigned C0_BITS     = 12;

    // whitening span is cut into equal segments, one register stage each
    localparam int unsigned SEG_COUNT   = 6;
    localparam int unsigned SEG_LEN     = WHITE_LEN / SEG_COUNT;

    // capture stage + segment stages + output register
    localparam int unsigned PIPE_DEPTH  = SEG_COUNT + 2;

    localparam logic [LCG_BITS-1:0] LCG_MUL = 16'd173;
    localparam logic [LCG_BITS-1:0] LCG_ADD = 16'd13849;

    typedef struct packed {
        logic [WORD_BITS-1:0] frame_bits_a;
        logic [WORD_BITS-1:0] frame_bits_b;
        logic [WORD_BITS-1:0] frame_bits_c;
    } in_t;

    typedef struct packed {
        logic [11:0] voice_c0;
        logic [11:0] voice_c1;
        logic [11:0] voice_c2;
        logic [11:0] voice_c3;
        logic [10:0] voice_c4;
        logic [10:0] voice_c5;
        logic [10:0] voice_c6;
        logic [6:0]  voice_c7;
    } out_t;

    // codeword bit 0 sits at cw[CW_BITS-1]
    typedef struct packed {
        logic [CW_BITS-1:0]  cw;
        logic [LCG_BITS-1:0] lcg;
    } stage_t;

    // multiplier of the n-step jump: p_n = mul(n) * p_0 + add(n)
    function automatic logic [LCG_BITS-1:0] lcg_jump_mul(input int unsigned n);
        logic [LCG_BITS-1:0] a;
        a = 16'd1;
        for (int unsigned i = 0; i < n; i++) begin
            a = LCG_BITS'(a * LCG_MUL);
        end
        return a;
    endfunction

    function automatic logic [LCG_BITS-1:0] lcg_jump_add(input int unsigned n);
        logic [LCG_BITS-1:0] b;
        b = '0;
        for (int unsigned i = 0; i < n; i++) begin
            b = LCG_BITS'(b * LCG_MUL) + LCG_ADD;
        end
        return b;
    endfunction

endpackage

@@ src/voice_frame_dewhitener.sv @@
// voice frame dewhitener: 144-bit codeword in, 88 voice bits out
// the codeword passes the capture, whitening segment and output registers in turn
// throughput: one codeword per cycle when not stalled, set by one lcg segment per stage
// backpressure ripples through per-stage ready, no stage ever drops or repeats
// reset (aresetn low at a clock edge) clears every stage valid bit
module voice_frame_dewhitener
    import vfdw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // stage chain: index 0 is the capture stage, SEG_COUNT is the last segment
    logic   seg_valid [0:SEG_COUNT];
    logic   seg_ready [0:SEG_COUNT];
    stage_t seg_data  [0:SEG_COUNT];

    // capture stage registers
    logic   cap_valid_reg;
    logic   cap_valid_next;
    stage_t cap_data_reg;
    stage_t cap_data_next;

    // output register
    logic   out_valid_reg;
    logic   out_valid_next;
    out_t   out_data_reg;
    out_t   out_data_next;
    logic   out_ready;

    logic [CW_BITS-1:0] final_cw;

    // ---------------- capture stage ----------------
    // c0 is the first 12 codeword bits; lcg seed is 16*c0 (mod 2^16)
    assign s_ready = !cap_valid_reg || seg_ready[0];

    always_comb begin
        cap_valid_next    = s_ready ? s_valid : cap_valid_reg;
        cap_data_next.cw  = {s_data.frame_bits_a, s_data.frame_bits_b, s_data.frame_bits_c};
        cap_data_next.lcg = {s_data.frame_bits_a[WORD_BITS-1 -: C0_BITS],
                             {SEED_SHIFT{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_valid_reg <= 1'b0;
        end else begin
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cap_data_reg <= cap_data_next;
        end
    end

    assign seg_valid[0] = cap_valid_reg;
    assign seg_data[0]  = cap_data_reg;

    // ---------------- whitening segments ----------------
    // each stage advances the lcg by SEG_LEN updates and flips SEG_LEN codeword bits
    for (genvar s = 0; s < SEG_COUNT; s++) begin : g_seg
        vfdw_seg #(
            .SEG_IDX (s)
        ) u_seg (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (seg_valid[s]),
            .up_ready (seg_ready[s]),
            .up_data  (seg_data[s]),
            .dn_valid (seg_valid[s+1]),
            .dn_ready (seg_ready[s+1]),
            .dn_data  (seg_data[s+1])
        );
    end

    // ---------------- output register ----------------
    assign out_ready            = !out_valid_reg || m_ready;
    assign seg_ready[SEG_COUNT] = out_ready;
    assign final_cw             = seg_data[SEG_COUNT].cw;

    // pick voice fields; codeword bit k sits at final_cw[CW_BITS-1-k]
    always_comb begin
        out_valid_next         = out_ready ? seg_valid[SEG_COUNT] : out_valid_reg;
        out_data_next.voice_c0 = final_cw[CW_BITS - 1 - 0   -: 12];
        out_data_next.voice_c1 = final_cw[CW_BITS - 1 - 23  -: 12];
        out_data_next.voice_c2 = final_cw[CW_BITS - 1 - 46  -: 12];
        out_data_next.voice_c3 = final_cw[CW_BITS - 1 - 69  -: 12];
        out_data_next.voice_c4 = final_cw[CW_BITS - 1 - 92  -: 11];
        out_data_next.voice_c5 = final_cw[CW_BITS - 1 - 107 -: 11];
        out_data_next.voice_c6 = final_cw[CW_BITS - 1 - 122 -: 11];
        out_data_next.voice_c7 = final_cw[CW_BITS - 1 - 137 -: 7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (seg_valid[SEG_COUNT] && out_ready) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ src/vfdw_seg.sv @@
module vfdw_seg
    import vfdw_pkg::*;
#(
    parameter int unsigned SEG_IDX = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn_data
);

    localparam int unsigned FIRST_BIT = WHITE_START + SEG_IDX * SEG_LEN;
    localparam logic [LCG_BITS-1:0] STEP_MUL = lcg_jump_mul(SEG_LEN);
    localparam logic [LCG_BITS-1:0] STEP_ADD = lcg_jump_add(SEG_LEN);

    logic               valid_reg;
    logic               valid_next;
    stage_t             data_reg;
    stage_t             data_next;
    logic [SEG_LEN-1:0] white_bits;
    logic [CW_BITS-1:0] white_mask;

    // lcg top bit after each update of this segment, all jumped from the stage input
    for (genvar j = 0; j < SEG_LEN; j++) begin : g_tap
        localparam logic [LCG_BITS-1:0] JMUL = lcg_jump_mul(j + 1);
        localparam logic [LCG_BITS-1:0] JADD = lcg_jump_add(j + 1);
        logic [LCG_BITS-1:0] tap_val;
        assign tap_val       = LCG_BITS'(JMUL * up_data.lcg) + JADD;
        assign white_bits[j] = tap_val[LCG_BITS-1];
    end

    always_comb begin
        white_mask = '0;
        for (int unsigned j = 0; j < SEG_LEN; j++) begin
            white_mask[CW_BITS - 1 - FIRST_BIT - j] = white_bits[j];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        valid_next    = up_ready ? up_valid : valid_reg;
        data_next.cw  = up_data.cw ^ white_mask;
        data_next.lcg = LCG_BITS'(STEP_MUL * up_data.lcg) + STEP_ADD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ src/vfdw_checker.sv @@
module vfdw_checker
    import vfdw_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    localparam int unsigned OCC_BITS = $clog2(PIPE_DEPTH + 1);

    logic [OCC_BITS-1:0] occ_reg;
    logic [OCC_BITS-1:0] occ_next;
    logic                in_xfer;
    logic                out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer) begin
            occ_next = occ_reg + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result without a codeword in flight
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != '0)
        else $error("result without accepted codeword");

    // never more codewords in flight than pipeline stages
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_BITS'(PIPE_DEPTH))
        else $error("pipeline holds too many codewords");

    // a free output side means the whole pipeline can move
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while output side free");

endmodule

bind voice_frame_dewhitener vfdw_checker u_vfdw_checker (.*);
